/* rtl/core/ssd_pkg.sv */
// Shared types, opcode and kind codes for the sequence command decoder.
package ssd_pkg;

   // Longest delay or duration run, in bytes.
   localparam int unsigned MAX_RUN_BYTES = 10;

   // Default number of result words the output queue holds.
   localparam int unsigned RSP_DEPTH = 4;

   // Field widths of one result word.
   localparam int unsigned KIND_W  = 5;
   localparam int unsigned VALUE_W = 60;
   localparam int unsigned LEN_W   = 4;

   // Byte classes of a run.
   localparam logic [7:0] RUN_CLASS_MASK = 8'hC0;
   localparam logic [7:0] RUN_DELAY      = 8'hC0;
   localparam logic [7:0] RUN_DURATION   = 8'h80;

   // Opcodes.
   localparam logic [7:0] OP_EOS        = 8'h60;
   localparam logic [7:0] OP_PATCH      = 8'h61;
   localparam logic [7:0] OP_MODULATION = 8'h62;
   localparam logic [7:0] OP_NOP        = 8'h63;
   localparam logic [7:0] OP_LOOP       = 8'h64;
   localparam logic [7:0] OP_LOOPEND    = 8'h65;
   localparam logic [7:0] OP_RETRIGGER  = 8'h66;
   localparam logic [7:0] OP_SUSTAIN    = 8'h67;
   localparam logic [7:0] OP_TEMPO      = 8'h68;
   localparam logic [7:0] OP_MUTE       = 8'h69;
   localparam logic [7:0] OP_PRIORITY   = 8'h6A;
   localparam logic [7:0] OP_PLAY       = 8'h6B;
   localparam logic [7:0] OP_PITCH      = 8'h6C;
   localparam logic [7:0] OP_SFX        = 8'h6D;
   localparam logic [7:0] OP_SAMPLERATE = 8'h6E;
   localparam logic [7:0] OP_GOTO       = 8'h6F;
   localparam logic [7:0] OP_MAILBOX    = 8'h70;
   localparam logic [7:0] OP_IF         = 8'h71;
   localparam logic [7:0] OP_EXTRA      = 8'h72;

   // Subcodes of the extra opcode.
   localparam logic [7:0] EXT_STOP         = 8'd0;
   localparam logic [7:0] EXT_PAUSE        = 8'd1;
   localparam logic [7:0] EXT_RESUME       = 8'd2;
   localparam logic [7:0] EXT_PAUSEL       = 8'd3;
   localparam logic [7:0] EXT_MASTERVOLUME = 8'd4;
   localparam logic [7:0] EXT_VOLUME       = 8'd5;

   // Condition codes of the if command run below this limit.
   localparam logic [7:0] IF_COND_LIMIT = 8'd6;

   // Tempo operands are reported with this offset added.
   localparam int unsigned TEMPO_OFFSET = 40;

   // Bit of the mute operand that carries the flag.
   localparam int unsigned MUTE_FLAG_BIT = 4;

   // Result kinds.
   localparam logic [4:0] KIND_DELAY         = 5'd0;
   localparam logic [4:0] KIND_DURATION      = 5'd1;
   localparam logic [4:0] KIND_NOTE          = 5'd2;
   localparam logic [4:0] KIND_EOS           = 5'd3;
   localparam logic [4:0] KIND_PATCH         = 5'd4;
   localparam logic [4:0] KIND_MODULATION    = 5'd5;
   localparam logic [4:0] KIND_NOP           = 5'd6;
   localparam logic [4:0] KIND_LOOP          = 5'd7;
   localparam logic [4:0] KIND_LOOPEND       = 5'd8;
   localparam logic [4:0] KIND_RETRIGGER     = 5'd9;
   localparam logic [4:0] KIND_SUSTAIN       = 5'd10;
   localparam logic [4:0] KIND_TEMPO         = 5'd11;
   localparam logic [4:0] KIND_MUTE          = 5'd12;
   localparam logic [4:0] KIND_PRIORITY      = 5'd13;
   localparam logic [4:0] KIND_PLAY          = 5'd14;
   localparam logic [4:0] KIND_PITCH         = 5'd15;
   localparam logic [4:0] KIND_SFX           = 5'd16;
   localparam logic [4:0] KIND_SAMPLERATE    = 5'd17;
   localparam logic [4:0] KIND_GOTO          = 5'd18;
   localparam logic [4:0] KIND_MAILBOX       = 5'd19;
   localparam logic [4:0] KIND_IF            = 5'd20;
   localparam logic [4:0] KIND_STOP          = 5'd21;
   localparam logic [4:0] KIND_PAUSE         = 5'd22;
   localparam logic [4:0] KIND_RESUME        = 5'd23;
   localparam logic [4:0] KIND_PAUSEL        = 5'd24;
   localparam logic [4:0] KIND_MASTERVOLUME  = 5'd25;
   localparam logic [4:0] KIND_VOLUME        = 5'd26;
   localparam logic [4:0] KIND_INVALID_EXTRA = 5'd27;
   localparam logic [4:0] KIND_INVALID       = 5'd28;
   localparam logic [4:0] KIND_TRUNCATED     = 5'd29;

   // One decoded result word.
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
      logic [7:0]         arg_first;
      logic [7:0]         arg_second;
      logic [7:0]         arg_third;
      logic [LEN_W-1:0]   length;
      logic               is_last;
   } rsp_word_type;

   // Words handed from the decoder to the output queue in one cycle.
   typedef struct packed {
      logic [1:0]   num;
      rsp_word_type first;
      rsp_word_type second;
   } push_type;

endpackage

/* rtl/core/ssd_if.sv */
// Valid/ready channel interfaces for bytecode input and decoded results.
interface ssd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       flush;

   modport source (output valid, output code_byte, output flush, input ready);
   modport sink   (input valid, input code_byte, input flush, output ready);
endinterface

interface ssd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ssd_pkg::KIND_W-1:0]   kind;
   logic [ssd_pkg::VALUE_W-1:0]  value;
   logic [7:0]                   arg_first;
   logic [7:0]                   arg_second;
   logic [7:0]                   arg_third;
   logic [ssd_pkg::LEN_W-1:0]    length;
   logic                         is_last;

   modport source (output valid, output kind, output value, output arg_first,
                   output arg_second, output arg_third, output length,
                   output is_last, input ready);
   modport sink   (input valid, input kind, input value, input arg_first,
                   input arg_second, input arg_third, input length,
                   input is_last, output ready);
endinterface

/* rtl/core/sound_sequence_command_decoder_core.sv */
// Top level of the sequence bytecode command decoder.
// The decoder takes one bytecode word per clock while the queue has room, and
// has its state updated at the same edge; every instruction that a word
// finishes becomes a result word written into an output queue of RSP_DEPTH
// entries, read one word per clock while the result side is ready. A word
// yields at most two results. Only a word that ends a run and also completes a
// one-byte instruction yields two, and the word before it opened or extended
// that run and yielded none. So while the result side takes a word every cycle
// the queue never holds more than two words, and with RSP_DEPTH of four or more
// the input takes one word per clock with no gaps. The input is ready whenever
// the queue has two free entries, independent of the result side in the same
// cycle, so it stalls only when results back up.
module sound_sequence_command_decoder_core #(
   parameter int unsigned RSP_DEPTH = ssd_pkg::RSP_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   ssd_req_if.sink      req,
   ssd_rsp_if.source    rsp
);

   ssd_pkg::push_type     push;
   ssd_pkg::rsp_word_type head;
   logic                  accept;
   logic                  dec_idle;

   assign accept = req.valid && req.ready;

   // Decode stage with the decoder state.
   ssd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .code_byte (req.code_byte),
      .flush     (req.flush),
      .push      (push),
      .idle      (dec_idle)
   );

   // Result queue between decode and the result channel.
   ssd_queue #(
      .DEPTH (RSP_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_ready (rsp.ready),
      .out_valid (rsp.valid),
      .head      (head),
      .in_ready  (req.ready)
   );

   // Result channel payload.
   assign rsp.kind       = head.kind;
   assign rsp.value      = head.value;
   assign rsp.arg_first  = head.arg_first;
   assign rsp.arg_second = head.arg_second;
   assign rsp.arg_third  = head.arg_third;
   assign rsp.length     = head.length;
   assign rsp.is_last    = head.is_last;

   // Results are only produced by an accepted word.
   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      (push.num != 2'd0) |-> accept)
      else $error("result pushed without an accepted word");

   // The last result of a word carries the end mark, and only that one.
   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      ((push.num == 2'd1) |-> push.first.is_last) and
      ((push.num == 2'd2) |-> (!push.first.is_last && push.second.is_last)))
      else $error("end mark on the wrong result word");

   // A flush leaves the decoder with nothing pending.
   a_flush_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && req.flush) |=> dec_idle)
      else $error("decoder not idle after flush");

   // A flush never produces two results.
   a_flush_single: assert property (@(posedge clock) disable iff (reset)
      (accept && req.flush) |-> (push.num != 2'd2))
      else $error("flush produced two results");

endmodule

/* rtl/core/ssd_decode.sv */
// Decoder state registers and the single-pass decode of one bytecode word.
module ssd_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        code_byte,
   input  logic              flush,
   output ssd_pkg::push_type push,
   output logic              idle
);

   typedef struct packed {
      logic [2:0]                  needed;
      logic [7:0]                  opcode;
      logic                        run_active;
      logic                        run_is_delay;
      logic [3:0]                  run_count;
      logic [ssd_pkg::VALUE_W-1:0] run_value;
   } dec_state_type;

   typedef struct packed {
      logic                  emit;
      ssd_pkg::rsp_word_type word;
      dec_state_type         st;
   } fresh_type;

   localparam logic [3:0] RUN_LIMIT = 4'(ssd_pkg::MAX_RUN_BYTES);

   dec_state_type state_ff, state_in;
   logic [7:0]    op_bytes_ff [4];
   logic [7:0]    op_bytes_in [4];

   // Total length of a command opcode; zero when the opcode is unknown.
   function automatic logic [2:0] cmd_length(input logic [7:0] op);
      logic [2:0] len;
      unique case (op)
         ssd_pkg::OP_EOS, ssd_pkg::OP_NOP, ssd_pkg::OP_LOOPEND, ssd_pkg::OP_SFX:
            len = 3'd1;
         ssd_pkg::OP_PITCH, ssd_pkg::OP_GOTO, ssd_pkg::OP_MAILBOX, ssd_pkg::OP_EXTRA:
            len = 3'd3;
         ssd_pkg::OP_IF:
            len = 3'd5;
         default:
            len = (op >= ssd_pkg::OP_PATCH && op <= ssd_pkg::OP_SAMPLERATE) ? 3'd2 : 3'd0;
      endcase
      return len;
   endfunction

   function automatic ssd_pkg::rsp_word_type make_word(
      input logic [4:0]                  kind,
      input logic [ssd_pkg::VALUE_W-1:0] value,
      input logic [7:0]                  a1,
      input logic [7:0]                  a2,
      input logic [7:0]                  a3,
      input logic [3:0]                  len
   );
      ssd_pkg::rsp_word_type w;
      w.kind       = kind;
      w.value      = value;
      w.arg_first  = a1;
      w.arg_second = a2;
      w.arg_third  = a3;
      w.length     = len;
      w.is_last    = 1'b0;
      return w;
   endfunction

   function automatic ssd_pkg::rsp_word_type run_word(input dec_state_type st);
      return make_word(st.run_is_delay ? ssd_pkg::KIND_DELAY : ssd_pkg::KIND_DURATION,
                       st.run_value, 8'd0, 8'd0, 8'd0, st.run_count);
   endfunction

   function automatic dec_state_type clear_run(input dec_state_type st);
      dec_state_type s;
      s            = st;
      s.run_active = 1'b0;
      s.run_count  = 4'd0;
      s.run_value  = '0;
      return s;
   endfunction

   // Decode a command whose operand bytes are all present.
   function automatic ssd_pkg::rsp_word_type finish_cmd(
      input logic [7:0] op,
      input logic [7:0] b1,
      input logic [7:0] b2,
      input logic [7:0] b3,
      input logic [7:0] b4
   );
      ssd_pkg::rsp_word_type w;
      logic                  flag;
      logic [7:0]            cond;
      flag = b1[ssd_pkg::MUTE_FLAG_BIT];
      cond = (b2 >= ssd_pkg::IF_COND_LIMIT) ? 8'd0 : b2;
      unique case (op)
         ssd_pkg::OP_PATCH:
            w = make_word(ssd_pkg::KIND_PATCH, 60'(b1), 8'd0, 8'd0, 8'd0, 4'd2);
         ssd_pkg::OP_MODULATION:
            w = make_word(ssd_pkg::KIND_MODULATION, 60'(b1), 8'd0, 8'd0, 8'd0, 4'd2);
         ssd_pkg::OP_LOOP:
            w = make_word(ssd_pkg::KIND_LOOP, 60'(b1), 8'd0, 8'd0, 8'd0, 4'd2);
         ssd_pkg::OP_RETRIGGER:
            w = make_word(ssd_pkg::KIND_RETRIGGER, 60'(b1 != 8'd0), 8'd0, 8'd0, 8'd0, 4'd2);
         ssd_pkg::OP_SUSTAIN:
            w = make_word(ssd_pkg::KIND_SUSTAIN, 60'(b1 != 8'd0), 8'd0, 8'd0, 8'd0, 4'd2);
         ssd_pkg::OP_TEMPO:
            w = make_word(ssd_pkg::KIND_TEMPO, 60'(b1) + 60'(ssd_pkg::TEMPO_OFFSET),
                          8'd0, 8'd0, 8'd0, 4'd2);
         ssd_pkg::OP_MUTE:
            w = make_word(ssd_pkg::KIND_MUTE, 60'(flag), 8'(flag), {4'd0, b1[3:0]},
                          8'd0, 4'd2);
         ssd_pkg::OP_PRIORITY:
            w = make_word(ssd_pkg::KIND_PRIORITY, 60'(b1), 8'd0, 8'd0, 8'd0, 4'd2);
         ssd_pkg::OP_PLAY:
            w = make_word(ssd_pkg::KIND_PLAY, 60'(b1), 8'd0, 8'd0, 8'd0, 4'd2);
         ssd_pkg::OP_PITCH:
            w = make_word(ssd_pkg::KIND_PITCH, 60'({b2, b1}), 8'd0, 8'd0, 8'd0, 4'd3);
         ssd_pkg::OP_SAMPLERATE:
            w = make_word(ssd_pkg::KIND_SAMPLERATE, 60'(b1), 8'd0, 8'd0, 8'd0, 4'd2);
         ssd_pkg::OP_GOTO:
            w = make_word(ssd_pkg::KIND_GOTO, 60'({b2, b1}), 8'd0, 8'd0, 8'd0, 4'd3);
         ssd_pkg::OP_MAILBOX:
            w = make_word(ssd_pkg::KIND_MAILBOX, '0, b1, b2, 8'd0, 4'd3);
         ssd_pkg::OP_IF:
            w = make_word(ssd_pkg::KIND_IF, 60'(b4), b1, cond, b3, 4'd5);
         ssd_pkg::OP_EXTRA: begin
            unique case (b1)
               ssd_pkg::EXT_STOP:
                  w = make_word(ssd_pkg::KIND_STOP, 60'(b2), 8'd0, 8'd0, 8'd0, 4'd3);
               ssd_pkg::EXT_PAUSE:
                  w = make_word(ssd_pkg::KIND_PAUSE, 60'(b2), 8'd0, 8'd0, 8'd0, 4'd3);
               ssd_pkg::EXT_RESUME:
                  w = make_word(ssd_pkg::KIND_RESUME, '0, 8'd0, 8'd0, 8'd0, 4'd3);
               ssd_pkg::EXT_PAUSEL:
                  w = make_word(ssd_pkg::KIND_PAUSEL, '0, 8'd0, 8'd0, 8'd0, 4'd3);
               ssd_pkg::EXT_MASTERVOLUME:
                  w = make_word(ssd_pkg::KIND_MASTERVOLUME, 60'(b2), 8'd0, 8'd0, 8'd0, 4'd3);
               ssd_pkg::EXT_VOLUME:
                  w = make_word(ssd_pkg::KIND_VOLUME, 60'(b2), 8'd0, 8'd0, 8'd0, 4'd3);
               default:
                  w = make_word(ssd_pkg::KIND_INVALID_EXTRA, '0, b1, b2, 8'd0, 4'd3);
            endcase
         end
         default:
            w = make_word(ssd_pkg::KIND_INVALID, 60'(op), 8'd0, 8'd0, 8'd0, 4'd1);
      endcase
      return w;
   endfunction

   // Decode a byte that opens a new instruction.
   function automatic fresh_type fresh_byte(input logic [7:0] b, input dec_state_type st_in);
      fresh_type  f;
      logic [2:0] len;
      f.emit = 1'b0;
      f.word = '0;
      f.st   = st_in;
      len    = cmd_length(b);
      if (b[7]) begin
         f.st.run_active   = 1'b1;
         f.st.run_is_delay = (b & ssd_pkg::RUN_CLASS_MASK) == ssd_pkg::RUN_DELAY;
         f.st.run_count    = 4'd1;
         f.st.run_value    = 60'(b[5:0]);
         if (4'd1 >= RUN_LIMIT) begin
            f.emit = 1'b1;
            f.word = run_word(f.st);
            f.st   = clear_run(f.st);
         end
      end else if (b < ssd_pkg::OP_EOS) begin
         f.emit = 1'b1;
         f.word = make_word(ssd_pkg::KIND_NOTE, 60'(b), 8'd0, 8'd0, 8'd0, 4'd1);
      end else if (len == 3'd0) begin
         f.emit = 1'b1;
         f.word = make_word(ssd_pkg::KIND_INVALID, 60'(b), 8'd0, 8'd0, 8'd0, 4'd1);
      end else if (len == 3'd1) begin
         f.emit = 1'b1;
         unique case (b)
            ssd_pkg::OP_EOS:
               f.word = make_word(ssd_pkg::KIND_EOS, '0, 8'd0, 8'd0, 8'd0, 4'd1);
            ssd_pkg::OP_NOP:
               f.word = make_word(ssd_pkg::KIND_NOP, '0, 8'd0, 8'd0, 8'd0, 4'd1);
            ssd_pkg::OP_LOOPEND:
               f.word = make_word(ssd_pkg::KIND_LOOPEND, '0, 8'd0, 8'd0, 8'd0, 4'd1);
            default:
               f.word = make_word(ssd_pkg::KIND_SFX, '0, 8'd0, 8'd0, 8'd0, 4'd1);
         endcase
      end else begin
         f.st.opcode = b;
         f.st.needed = len - 3'd1;
      end
      return f;
   endfunction

   // Next state and the results of the accepted word.
   always_comb begin
      dec_state_type         st;
      fresh_type             f;
      ssd_pkg::rsp_word_type w0;
      ssd_pkg::rsp_word_type w1;
      logic [1:0]            num;
      logic [2:0]            total;
      logic [2:0]            got;
      logic [1:0]            idx;
      logic [7:0]            cls;

      st          = state_ff;
      op_bytes_in = op_bytes_ff;
      w0          = '0;
      w1          = '0;
      num         = 2'd0;
      f           = '0;
      total       = cmd_length(state_ff.opcode);
      got         = (total > state_ff.needed) ? total - state_ff.needed : 3'd1;
      idx         = 2'(total - 3'd1 - state_ff.needed);
      cls         = state_ff.run_is_delay ? ssd_pkg::RUN_DELAY : ssd_pkg::RUN_DURATION;

      if (accept) begin
         if (flush) begin
            // End of stream: report what is pending and start over.
            if (st.needed != 3'd0) begin
               w0  = make_word(ssd_pkg::KIND_TRUNCATED, 60'(st.opcode), 8'd0, 8'd0, 8'd0,
                               4'(got));
               num = 2'd1;
            end else if (st.run_active) begin
               w0  = run_word(st);
               num = 2'd1;
            end
            st = '0;
         end else if (st.needed != 3'd0) begin
            // Every byte is an operand while a command waits for one.
            op_bytes_in[idx] = code_byte;
            st.needed        = st.needed - 3'd1;
            if (st.needed == 3'd0) begin
               w0  = finish_cmd(st.opcode, op_bytes_in[0], op_bytes_in[1],
                                op_bytes_in[2], op_bytes_in[3]);
               num = 2'd1;
            end
         end else if (st.run_active) begin
            if ((code_byte & ssd_pkg::RUN_CLASS_MASK) == cls) begin
               // Same class: six more bits join the run.
               st.run_value = {st.run_value[ssd_pkg::VALUE_W-7:0], code_byte[5:0]};
               st.run_count = st.run_count + 4'd1;
               if (st.run_count >= RUN_LIMIT) begin
                  w0  = run_word(st);
                  num = 2'd1;
                  st  = clear_run(st);
               end
            end else begin
               // Other class: the run ends and the byte is decoded afresh.
               w0  = run_word(st);
               num = 2'd1;
               st  = clear_run(st);
               f   = fresh_byte(code_byte, st);
               st  = f.st;
               if (f.emit) begin
                  w1  = f.word;
                  num = 2'd2;
               end
            end
         end else begin
            f  = fresh_byte(code_byte, st);
            st = f.st;
            if (f.emit) begin
               w0  = f.word;
               num = 2'd1;
            end
         end
         if (num == 2'd1) begin
            w0.is_last = 1'b1;
         end
         if (num == 2'd2) begin
            w1.is_last = 1'b1;
         end
      end

      state_in    = st;
      push.num    = num;
      push.first  = w0;
      push.second = w1;
   end

   // Control state resets; operand bytes are written before they are read.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_bytes_ff <= op_bytes_in;
      end
   end

   assign idle = (state_ff.needed == 3'd0) && !state_ff.run_active;

endmodule

/* rtl/core/ssd_queue.sv */
// Result queue that takes up to two words a cycle and hands out one while the reader is ready.
module ssd_queue #(
   parameter int unsigned DEPTH = ssd_pkg::RSP_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ssd_pkg::push_type     push,
   input  logic                  out_ready,
   output logic                  out_valid,
   output ssd_pkg::rsp_word_type head,
   output logic                  in_ready
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] ROOM_MARK = CNT_W'(DEPTH - 2);

   ssd_pkg::rsp_word_type mem_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [PTR_W-1:0]      wr_next;
   logic                  pop;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
   endfunction

   assign wr_next   = next_ptr(wr_ptr_ff);
   assign out_valid = count_ff != '0;
   assign pop       = out_valid && out_ready;
   assign head      = mem_ff[rd_ptr_ff];
   // Room for two words is kept so that any word can be taken.
   assign in_ready  = count_ff <= ROOM_MARK;

   // Pointer and fill count updates.
   always_comb begin
      unique case (push.num)
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = next_ptr(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.num) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Word storage.
   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.num == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

endmodule

/* dv/ssd_result_checker.sv */
// Scoreboard for the sequence command decoder: predicts decoded words and compares results.
module ssd_result_checker
   import ssd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ssd_req_if          req_mon,
   ssd_rsp_if          rsp_mon,
   output int unsigned fail_count,
   output int unsigned pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Decoder state as the predictor sees it.
   logic [2:0]         wait_count;
   logic [7:0]         held_opcode;
   logic [7:0]         operand_buf [4];
   logic               run_open;
   logic               run_delay;
   logic [LEN_W-1:0]   run_len;
   logic [VALUE_W-1:0] run_acc;

   // Decoded words still to come out of the block, oldest first.
   rsp_word_type expected_cmds[$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // Total instruction length of an opcode; zero for an unknown one.
   function automatic logic [2:0] opcode_bytes(input logic [7:0] op);
      case (op)
         OP_EOS, OP_NOP, OP_LOOPEND, OP_SFX:       return 3'd1;
         OP_PITCH, OP_GOTO, OP_MAILBOX, OP_EXTRA:  return 3'd3;
         OP_IF:                                    return 3'd5;
         default: return (op >= OP_PATCH && op <= OP_SAMPLERATE) ? 3'd2 : 3'd0;
      endcase
   endfunction

   task automatic clear_state();
      wait_count  = '0;
      held_opcode = '0;
      foreach (operand_buf[i]) operand_buf[i] = '0;
      run_open    = 1'b0;
      run_delay   = 1'b0;
      run_len     = '0;
      run_acc     = '0;
   endtask

   task automatic add_expected(input logic [KIND_W-1:0] kind,
                               input logic [VALUE_W-1:0] value,
                               input logic [7:0] a1, input logic [7:0] a2,
                               input logic [7:0] a3, input logic [LEN_W-1:0] len);
      rsp_word_type w;
      w.kind       = kind;
      w.value      = value;
      w.arg_first  = a1;
      w.arg_second = a2;
      w.arg_third  = a3;
      w.length     = len;
      w.is_last    = 1'b0;
      expected_cmds = {expected_cmds, w};
   endtask

   task automatic close_run();
      add_expected(run_delay ? KIND_DELAY : KIND_DURATION, run_acc, 8'd0, 8'd0, 8'd0,
                   run_len);
      run_open = 1'b0;
      run_len  = '0;
      run_acc  = '0;
   endtask

   // All operands of the held opcode are in: produce its command.
   task automatic decode_command();
      logic [7:0] b1, b2, b3, b4;
      b1 = operand_buf[0];
      b2 = operand_buf[1];
      b3 = operand_buf[2];
      b4 = operand_buf[3];
      case (held_opcode)
         OP_PATCH:
            add_expected(KIND_PATCH, VALUE_W'(b1), 8'd0, 8'd0, 8'd0, 4'd2);
         OP_MODULATION:
            add_expected(KIND_MODULATION, VALUE_W'(b1), 8'd0, 8'd0, 8'd0, 4'd2);
         OP_LOOP:
            add_expected(KIND_LOOP, VALUE_W'(b1), 8'd0, 8'd0, 8'd0, 4'd2);
         OP_RETRIGGER:
            add_expected(KIND_RETRIGGER, VALUE_W'(b1 != 8'd0), 8'd0, 8'd0, 8'd0, 4'd2);
         OP_SUSTAIN:
            add_expected(KIND_SUSTAIN, VALUE_W'(b1 != 8'd0), 8'd0, 8'd0, 8'd0, 4'd2);
         OP_TEMPO:
            add_expected(KIND_TEMPO, VALUE_W'(b1) + VALUE_W'(TEMPO_OFFSET),
                         8'd0, 8'd0, 8'd0, 4'd2);
         OP_MUTE:
            add_expected(KIND_MUTE, VALUE_W'(b1[MUTE_FLAG_BIT]), 8'(b1[MUTE_FLAG_BIT]),
                         {4'h0, b1[3:0]}, 8'd0, 4'd2);
         OP_PRIORITY:
            add_expected(KIND_PRIORITY, VALUE_W'(b1), 8'd0, 8'd0, 8'd0, 4'd2);
         OP_PLAY:
            add_expected(KIND_PLAY, VALUE_W'(b1), 8'd0, 8'd0, 8'd0, 4'd2);
         OP_PITCH:
            add_expected(KIND_PITCH, VALUE_W'({b2, b1}), 8'd0, 8'd0, 8'd0, 4'd3);
         OP_SAMPLERATE:
            add_expected(KIND_SAMPLERATE, VALUE_W'(b1), 8'd0, 8'd0, 8'd0, 4'd2);
         OP_GOTO:
            add_expected(KIND_GOTO, VALUE_W'({b2, b1}), 8'd0, 8'd0, 8'd0, 4'd3);
         OP_MAILBOX:
            add_expected(KIND_MAILBOX, '0, b1, b2, 8'd0, 4'd3);
         // Condition codes past the last valid one collapse to zero.
         OP_IF:
            add_expected(KIND_IF, VALUE_W'(b4), b1, (b2 >= IF_COND_LIMIT) ? 8'd0 : b2, b3,
                         4'd5);
         OP_EXTRA:
            case (b1)
               EXT_STOP:
                  add_expected(KIND_STOP, VALUE_W'(b2), 8'd0, 8'd0, 8'd0, 4'd3);
               EXT_PAUSE:
                  add_expected(KIND_PAUSE, VALUE_W'(b2), 8'd0, 8'd0, 8'd0, 4'd3);
               EXT_RESUME:
                  add_expected(KIND_RESUME, '0, 8'd0, 8'd0, 8'd0, 4'd3);
               EXT_PAUSEL:
                  add_expected(KIND_PAUSEL, '0, 8'd0, 8'd0, 8'd0, 4'd3);
               EXT_MASTERVOLUME:
                  add_expected(KIND_MASTERVOLUME, VALUE_W'(b2), 8'd0, 8'd0, 8'd0, 4'd3);
               EXT_VOLUME:
                  add_expected(KIND_VOLUME, VALUE_W'(b2), 8'd0, 8'd0, 8'd0, 4'd3);
               default:
                  add_expected(KIND_INVALID_EXTRA, '0, b1, b2, 8'd0, 4'd3);
            endcase
         default:
            add_expected(KIND_INVALID, VALUE_W'(held_opcode), 8'd0, 8'd0, 8'd0, 4'd1);
      endcase
   endtask

   // A word that opens a new instruction.
   task automatic start_instruction(input logic [7:0] b);
      logic [2:0] total;
      total = opcode_bytes(b);
      if (b[7]) begin
         run_open  = 1'b1;
         run_delay = (b & RUN_CLASS_MASK) == RUN_DELAY;
         run_len   = 4'd1;
         run_acc   = VALUE_W'(b[5:0]);
         if (run_len >= MAX_RUN_BYTES) close_run();
      end else if (b < OP_EOS) begin
         add_expected(KIND_NOTE, VALUE_W'(b), 8'd0, 8'd0, 8'd0, 4'd1);
      end else if (total == 3'd0) begin
         add_expected(KIND_INVALID, VALUE_W'(b), 8'd0, 8'd0, 8'd0, 4'd1);
      end else if (total == 3'd1) begin
         case (b)
            OP_EOS:     add_expected(KIND_EOS, '0, 8'd0, 8'd0, 8'd0, 4'd1);
            OP_NOP:     add_expected(KIND_NOP, '0, 8'd0, 8'd0, 8'd0, 4'd1);
            OP_LOOPEND: add_expected(KIND_LOOPEND, '0, 8'd0, 8'd0, 8'd0, 4'd1);
            default:    add_expected(KIND_SFX, '0, 8'd0, 8'd0, 8'd0, 4'd1);
         endcase
      end else begin
         held_opcode = b;
         wait_count  = total - 3'd1;
      end
   endtask

   // Advance the predictor by one accepted input word.
   task automatic decode_word(input logic [7:0] b, input logic fl);
      int unsigned  prior_size;
      logic [2:0]   total;
      prior_size = expected_cmds.size();
      total = opcode_bytes(held_opcode);
      if (fl) begin
         // End of stream: report a partial command or close an open run.
         if (wait_count != 3'd0)
            add_expected(KIND_TRUNCATED, VALUE_W'(held_opcode), 8'd0, 8'd0, 8'd0,
                         LEN_W'((total > wait_count) ? total - wait_count : 3'd1));
         else if (run_open)
            close_run();
         clear_state();
      end else if (wait_count != 3'd0) begin
         // Operand bytes are taken whatever their top bits.
         operand_buf[2'(total - 3'd1 - wait_count)] = b;
         wait_count = wait_count - 3'd1;
         if (wait_count == 3'd0) decode_command();
      end else if (run_open) begin
         if ((b & RUN_CLASS_MASK) == (run_delay ? RUN_DELAY : RUN_DURATION)) begin
            run_acc = {run_acc[VALUE_W-7:0], b[5:0]};
            run_len = run_len + 4'd1;
            if (run_len >= MAX_RUN_BYTES) close_run();
         end else begin
            close_run();
            start_instruction(b);
         end
      end else begin
         start_instruction(b);
      end
      if (expected_cmds.size() > prior_size)
         expected_cmds[expected_cmds.size() - 1].is_last = 1'b1;
   endtask

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Compare finished results, then feed the predictor with accepted input words.
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         clear_state();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_cmds.size() == 0) begin
               $error("result word with none expected: kind 0x%0h value 0x%0h",
                      rsp_mon.kind, rsp_mon.value);
               fail_count++;
            end else begin
               want = expected_cmds.pop_front();
               check_field("kind", 64'(want.kind), 64'(rsp_mon.kind));
               check_field("value", 64'(want.value), 64'(rsp_mon.value));
               check_field("arg_first", 64'(want.arg_first), 64'(rsp_mon.arg_first));
               check_field("arg_second", 64'(want.arg_second), 64'(rsp_mon.arg_second));
               check_field("arg_third", 64'(want.arg_third), 64'(rsp_mon.arg_third));
               check_field("length", 64'(want.length), 64'(rsp_mon.length));
               check_field("is_last", 64'(want.is_last), 64'(rsp_mon.is_last));
            end
         end
         if (req_mon.valid && req_mon.ready)
            decode_word(req_mon.code_byte, req_mon.flush);
      end
      pending_count = expected_cmds.size();
   end

endmodule

/* dv/sound_sequence_command_decoder_core_test.sv */
// Top of the sequence command decoder testbench: clock, reset, stimulus and verdict.
module sound_sequence_command_decoder_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ssd_pkg::*;

   localparam int         WATCHDOG_LIMIT = 4000;
   localparam int         HOLD_CYCLES    = 300;
   localparam int         END_DRAIN      = 16;
   // Last code of the opcode space; codes above the extra opcode are unknown.
   localparam logic [7:0] OP_SPACE_LAST  = 8'h7F;

   logic        clock = 1'b0;
   logic        reset;
   int unsigned fail_count;
   int unsigned pending_count;

   int idle_pct    = 0;
   int stall_pct   = 0;
   int words_sent  = 0;
   int quiet_cycles = 0;
   int hold_left   = 0;
   bit hold_armed  = 1'b0;

   ssd_req_if req_ch ();
   ssd_rsp_if rsp_ch ();

   sound_sequence_command_decoder_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   ssd_result_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #1 clock = ~clock;

   // Result side: random stalls, plus one long hold-off when armed.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_armed) begin
            hold_left  = HOLD_CYCLES;
            hold_armed = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Give up when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("sound_sequence_command_decoder_core_test: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one word after a random gap and wait until it is taken.
   task automatic send_word(input logic [7:0] b, input logic fl);
      int gap;
      gap = 0;
      while (gap < 200 && $urandom_range(99) < idle_pct) gap++;
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid     <= 1'b0;
         req_ch.code_byte <= 8'($urandom);
         req_ch.flush     <= 1'($urandom);
      end
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.code_byte <= b;
      req_ch.flush     <= fl;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
   endtask

   function automatic int operand_count(input logic [7:0] op);
      case (op)
         OP_EOS, OP_NOP, OP_LOOPEND, OP_SFX:      return 0;
         OP_PITCH, OP_GOTO, OP_MAILBOX, OP_EXTRA: return 2;
         OP_IF:                                   return 4;
         default:                                 return 1;
      endcase
   endfunction

   // Operand values lean toward the extremes now and then.
   function automatic logic [7:0] operand_byte();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // One random instruction: mostly well formed, some noise and cut-off commands.
   task automatic send_instruction();
      int         pick;
      int         n;
      logic [7:0] op;
      logic [7:0] run_class;
      pick = $urandom_range(99);
      if (pick < 40) begin
         op = 8'($urandom_range(OP_EOS, OP_EXTRA));
         send_word(op, 1'b0);
         n = operand_count(op);
         for (int i = 0; i < n; i++) begin
            if (i == 0 && op == OP_EXTRA && $urandom_range(3) != 0)
               send_word(8'($urandom_range(7)), 1'b0);
            else if (i == 1 && op == OP_IF && $urandom_range(3) != 0)
               send_word(8'($urandom_range(7)), 1'b0);
            else
               send_word(operand_byte(), 1'b0);
         end
      end else if (pick < 62) begin
         // Delay or duration run, sometimes longer than one full run.
         run_class = $urandom_range(1) ? RUN_DELAY : RUN_DURATION;
         n = ($urandom_range(9) == 0) ? $urandom_range(11, 22) : $urandom_range(1, 10);
         repeat (n)
            send_word(run_class | (($urandom_range(7) == 0) ? 8'h3F : 8'($urandom_range(63))),
                      1'b0);
      end else if (pick < 75) begin
         send_word(8'($urandom_range(OP_EOS - 8'd1)), 1'b0);
      end else if (pick < 80) begin
         send_word(8'($urandom_range(OP_EXTRA + 8'd1, OP_SPACE_LAST)), 1'b0);
      end else if (pick < 86) begin
         send_word(8'($urandom), 1'b1);
      end else if (pick < 94) begin
         send_word(8'($urandom), 1'b0);
      end else begin
         // Command cut short by the end of the stream.
         op = 8'($urandom_range(OP_PATCH, OP_EXTRA));
         send_word(op, 1'b0);
         n = operand_count(op);
         if (n > 0) repeat ($urandom_range(n - 1)) send_word(operand_byte(), 1'b0);
         send_word(8'($urandom), 1'b1);
      end
   endtask

   task automatic run_phase(input int target, input int idle, input int stall);
      int start_count;
      idle_pct    = idle;
      stall_pct   = stall;
      start_count = words_sent;
      while (words_sent - start_count < target) send_instruction();
   endtask

   // Stimulus: reset, directed corner cases, random phases, pressure, drain.
   initial begin
      logic [8:0] directed_q[$];
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.code_byte = 8'h00;
      req_ch.flush     = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Lowest and highest note, then a full delay run of all ones.
      send_word(8'h00, 1'b0);
      send_word(OP_EOS - 8'd1, 1'b0);
      repeat (MAX_RUN_BYTES) send_word(8'hFF, 1'b0);
      directed_q = {
         // New delay run, a duration run ends it, eos ends that one too.
         {1'b0, 8'hFF}, {1'b0, RUN_DURATION}, {1'b0, OP_EOS},
         // Unknown opcodes.
         {1'b0, OP_SPACE_LAST}, {1'b0, OP_EXTRA + 8'd1},
         // If with out-of-range condition; operands with run-like top bits.
         {1'b0, OP_IF}, {1'b0, 8'h01}, {1'b0, IF_COND_LIMIT}, {1'b0, 8'hFF}, {1'b0, 8'h80},
         // Unknown extra subcode.
         {1'b0, OP_EXTRA}, {1'b0, 8'hFF}, {1'b0, 8'hC3},
         // Flush with a partial command, with an open run, and when idle.
         {1'b0, OP_PITCH}, {1'b0, 8'h12}, {1'b1, 8'h00},
         {1'b0, 8'hC5}, {1'b1, 8'hFF}, {1'b1, 8'h5A}
      };
      foreach (directed_q[i]) send_word(directed_q[i][7:0], directed_q[i][8]);

      run_phase(420, 0, 0);
      run_phase(420, 86, 0);
      run_phase(420, 0, 86);
      run_phase(420, 15, 15);

      // Long result hold-off while words keep coming, so the input stalls.
      hold_armed = 1'b1;
      run_phase(80, 0, 0);

      @(negedge clock);
      req_ch.valid <= 1'b0;
      stall_pct = 0;
      while (pending_count != 0) @(negedge clock);
      repeat (END_DRAIN) @(negedge clock);

      if (fail_count == 0 && pending_count == 0)
         $display("sound_sequence_command_decoder_core_test: done, clean");
      else
         $display("sound_sequence_command_decoder_core_test: done, errors");
      $finish;
   end

endmodule
